[hdl/egti_pkg.sv]
package egti_pkg;

	localparam int TABLE_POINTS = 42;
	localparam int IDX_W        = $clog2(TABLE_POINTS);
	localparam int POS_W        = 31;
	localparam int OUT_W        = 44;
	localparam int RAD_W        = 30;
	localparam int RESP_W       = 20;
	localparam int DIST_W       = 32;
	localparam int ACC_W        = 64;
	localparam int MUL_W        = 33;
	localparam int CS_W         = 48;
	localparam int REM_W        = CS_W - 1;
	localparam int VM_W         = 35;
	localparam int D_W          = 46;
	localparam int FRAC_V       = 16;
	localparam int FRAC_OUT     = 30;
	localparam int SQRT_ITERS   = DIST_W;
	localparam int DIV1_BITS    = VM_W + 1;
	localparam int DIV2_BITS    = OUT_W;
	localparam int CNT_W        = $clog2(DIV2_BITS);
	localparam int VAL_SCALE    = 10000;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 1'b1;

	// radius breakpoints in 1/64 m units
	localparam logic [RAD_W-1:0] RADIUS_BP [TABLE_POINTS] = '{
		30'd0, 30'd704, 30'd7104, 30'd71168, 30'd142336, 30'd213504, 30'd284672,
		30'd427008, 30'd569344, 30'd711680, 30'd1138560, 30'd1423360, 30'd1779200,
		30'd2135040, 30'd2846720, 30'd3558400, 30'd4270080, 30'd5693440, 30'd7116800,
		30'd8537600, 30'd11385600, 30'd14233600, 30'd17792000, 30'd21350400,
		30'd28467200, 30'd35584000, 30'd42700800, 30'd49817600, 30'd56934400,
		30'd64064000, 30'd71168000, 30'd85376000, 30'd113856000, 30'd142336000,
		30'd177920000, 30'd213504000, 30'd284672000, 30'd355840000, 30'd427008000,
		30'd498176000, 30'd569344000, 30'd640512000
	};

	// tabulated response times 10000
	localparam logic signed [RESP_W-1:0] RESP_TAB [TABLE_POINTS] = '{
		-20'sd336488, -20'sd336400, -20'sd335600, -20'sd327500, -20'sd318600,
		-20'sd309800, -20'sd301200, -20'sd284400, -20'sd268700, -20'sd254100,
		-20'sd218000, -20'sd200200, -20'sd183600, -20'sd171800, -20'sd157100,
		-20'sd149100, -20'sd144100, -20'sd136900, -20'sd130100, -20'sd123100,
		-20'sd109500, -20'sd97570, -20'sd85190, -20'sd75330, -20'sd61310,
		-20'sd52370, -20'sd46600, -20'sd42720, -20'sd39990, -20'sd37980,
		-20'sd36400, -20'sd33920, -20'sd29990, -20'sd26190, -20'sd21030,
		-20'sd15300, -20'sd2920, 20'sd8480, 20'sd16760, 20'sd20830,
		20'sd20570, 20'sd16430
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_SQRT,
		ST_RCHK,
		ST_SRCH,
		ST_MULW,
		ST_MULT,
		ST_NUM,
		ST_D1INIT,
		ST_DIV1,
		ST_DSCL,
		ST_DLD,
		ST_DIV2,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic            ge;
		logic [CS_W-1:0] diff;
	} cs_res_t;

endpackage

[hdl/elastic_greens_table_interp.sv]
// one item in flight: a new input is taken only in the idle state; zero distance,
// out-of-range distance and saturation skip part of the sequence, which is
// built from the 32-step square root and the 36- and 44-step restoring divisions,
// all through one shared compare-subtract unit, plus a shared 33x33 multiplier
// reset clears both center registers to zero and empties the block and its output register
module elastic_greens_table_interp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [egti_pkg::POS_W-1:0]     x_pos,
	input  logic signed [egti_pkg::POS_W-1:0]     y_pos,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [egti_pkg::OUT_W-1:0]     green_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [egti_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic signed [egti_pkg::POS_W-1:0]     cfg_data
);
	import egti_pkg::*;

	localparam logic [OUT_W-1:0] OUT_MAXPOS = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MINMAG = {1'b1, {(OUT_W-1){1'b0}}};
	localparam int D1_SHIFT = DIV1_BITS - FRAC_V;
	localparam int D2_SHIFT = DIV2_BITS - FRAC_OUT;

	state_t state_q, state_d;

	logic signed [POS_W-1:0]   cx_q, cy_q;
	logic        [DIST_W-1:0]  ax_q, ay_q;
	logic        [ACC_W-1:0]   acc_q;
	logic        [REM_W-1:0]   rem_q;
	logic        [OUT_W-1:0]   q_q;
	logic        [DIST_W-1:0]  r_q;
	logic        [RAD_W-1:0]   w_q, t_q;
	logic        [VM_W-1:0]    vm_q;
	logic        [D_W-1:0]     d_q;
	logic                      neg_q;
	logic        [CNT_W-1:0]   cnt_q;
	logic        [IDX_W-1:0]   lo_q, hi_q;
	logic        [OUT_W-1:0]   res_q;
	logic                      out_valid_q;

	logic signed [DIST_W-1:0]  dx_c, dy_c;
	logic        [ACC_W-1:0]   mag_c;
	logic        [IDX_W:0]     mid_sum_c;
	logic        [IDX_W-1:0]   mid_c, idx1_c;
	logic        [RAD_W-1:0]   w_c;
	logic signed [RESP_W:0]    dresp_c;
	logic        [RESP_W-1:0]  rt0_mag_c;
	logic        [OUT_W-1:0]   res_c;
	logic                      last_c, fin_fire_c;

	logic        [CS_W-1:0]    cs_a, cs_b;
	cs_res_t                   cs_res;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	egti_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	egti_cmpsub u_cmpsub (
		.a   (cs_a),
		.b   (cs_b),
		.res (cs_res)
	);

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign green_value = res_q;

	always_comb begin
		dx_c      = DIST_W'(cx_q) - DIST_W'(x_pos);
		dy_c      = DIST_W'(cy_q) - DIST_W'(y_pos);
		mag_c     = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
		mid_sum_c = {1'b0, lo_q} + {1'b0, hi_q} + (IDX_W+1)'(1);
		mid_c     = mid_sum_c[IDX_W:1];
		idx1_c    = lo_q + IDX_W'(1);
		w_c       = RADIUS_BP[idx1_c] - RADIUS_BP[lo_q];
		dresp_c   = (RESP_W+1)'(RESP_TAB[idx1_c]) - (RESP_W+1)'(RESP_TAB[lo_q]);
		rt0_mag_c = RESP_TAB[0][RESP_W-1] ? RESP_W'(-RESP_TAB[0]) : RESP_TAB[0];
		if (neg_q) begin
			res_c = q_q[OUT_W-1] ? OUT_MINMAG : (OUT_W'(0) - q_q);
		end else begin
			res_c = q_q[OUT_W-1] ? OUT_MAXPOS : q_q;
		end
		fin_fire_c = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	// shared unit operand select
	always_comb begin
		cs_a   = '0;
		cs_b   = '0;
		mul_a  = '0;
		mul_b  = '0;
		last_c = 1'b0;
		unique case (state_q)
			ST_SQX: begin
				mul_a = MUL_W'(ax_q);
				mul_b = MUL_W'(ax_q);
			end
			ST_SQY: begin
				mul_a = MUL_W'(ay_q);
				mul_b = MUL_W'(ay_q);
			end
			ST_SQRT: begin
				cs_a   = CS_W'({rem_q[REM_W-3:0], acc_q[ACC_W-1 -: 2]});
				cs_b   = CS_W'({q_q[SQRT_ITERS-1:0], 2'b01});
				last_c = (cnt_q == CNT_W'(SQRT_ITERS - 1));
			end
			ST_SRCH: begin
				cs_a = CS_W'(r_q);
				cs_b = CS_W'(RADIUS_BP[mid_c]);
			end
			ST_MULW: begin
				mul_a = MUL_W'(RESP_TAB[lo_q]);
				mul_b = MUL_W'(w_c);
			end
			ST_MULT: begin
				mul_a = MUL_W'(dresp_c);
				mul_b = MUL_W'(t_q);
			end
			ST_DIV1: begin
				cs_a   = {rem_q, acc_q[ACC_W-1]};
				cs_b   = CS_W'(w_q);
				last_c = (cnt_q == CNT_W'(DIV1_BITS - 1));
			end
			ST_DSCL: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(VAL_SCALE);
			end
			ST_DLD: begin
				cs_a = CS_W'(vm_q >> D2_SHIFT);
				cs_b = CS_W'(mul_p[D_W-1:0]);
			end
			ST_DIV2: begin
				cs_a   = {rem_q, acc_q[ACC_W-1]};
				cs_b   = CS_W'(d_q);
				last_c = (cnt_q == CNT_W'(DIV2_BITS - 1));
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SQX;
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_SQRT;
			ST_SQRT:   if (last_c) state_d = ST_RCHK;
			ST_RCHK: begin
				if (r_q == '0) begin
					state_d = ST_DSCL;
				end else if (r_q > DIST_W'(RADIUS_BP[TABLE_POINTS-1])) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH:   if (!(lo_q < hi_q)) state_d = ST_MULW;
			ST_MULW:   state_d = ST_MULT;
			ST_MULT:   state_d = ST_NUM;
			ST_NUM:    state_d = ST_D1INIT;
			ST_D1INIT: state_d = ST_DIV1;
			ST_DIV1:   if (last_c) state_d = ST_DSCL;
			ST_DSCL:   state_d = ST_DLD;
			ST_DLD:    state_d = cs_res.ge ? ST_FIN : ST_DIV2;
			ST_DIV2:   if (last_c) state_d = ST_FIN;
			ST_FIN:    if (fin_fire_c) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer counters and output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_SUM, ST_D1INIT, ST_DLD: cnt_q <= '0;
				ST_SQRT, ST_DIV1, ST_DIV2: cnt_q <= cnt_q + CNT_W'(1);
				default: ;
			endcase
			if (state_q == ST_RCHK) begin
				lo_q <= '0;
				hi_q <= IDX_W'(TABLE_POINTS - 2);
			end else if (state_q == ST_SRCH && lo_q < hi_q) begin
				if (cs_res.ge) begin
					lo_q <= mid_c;
				end else begin
					hi_q <= mid_c - IDX_W'(1);
				end
			end
			if (fin_fire_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q <= dx_c[DIST_W-1] ? DIST_W'(-dx_c) : DIST_W'(dx_c);
				ay_q <= dy_c[DIST_W-1] ? DIST_W'(-dy_c) : DIST_W'(dy_c);
			end
			ST_SQY: acc_q <= mul_p[ACC_W-1:0];
			ST_SUM: begin
				acc_q <= acc_q + mul_p[ACC_W-1:0];
				rem_q <= '0;
				q_q   <= '0;
			end
			ST_SQRT, ST_DIV1, ST_DIV2: begin
				rem_q <= cs_res.ge ? cs_res.diff[REM_W-1:0] : cs_a[REM_W-1:0];
				q_q   <= {q_q[OUT_W-2:0], cs_res.ge};
				if (state_q == ST_SQRT) begin
					acc_q <= acc_q << 2;
					if (last_c) r_q <= {q_q[DIST_W-2:0], cs_res.ge};
				end else begin
					acc_q <= acc_q << 1;
					if (state_q == ST_DIV1 && last_c) vm_q <= {q_q[VM_W-2:0], cs_res.ge};
				end
			end
			ST_RCHK: begin
				if (r_q == '0) begin
					r_q   <= DIST_W'(RADIUS_BP[1]);
					vm_q  <= VM_W'(rt0_mag_c) << FRAC_V;
					neg_q <= RESP_TAB[0][RESP_W-1];
				end else begin
					q_q   <= '0;
					neg_q <= 1'b0;
				end
			end
			ST_MULW: begin
				w_q <= w_c;
				t_q <= RAD_W'(r_q - DIST_W'(RADIUS_BP[lo_q]));
			end
			ST_MULT: acc_q <= mul_p[ACC_W-1:0];
			ST_NUM:  acc_q <= acc_q + mul_p[ACC_W-1:0];
			ST_D1INIT: begin
				neg_q <= acc_q[ACC_W-1];
				rem_q <= REM_W'(mag_c >> D1_SHIFT);
				acc_q <= mag_c << (ACC_W - D1_SHIFT);
				q_q   <= '0;
			end
			ST_DLD: begin
				d_q <= mul_p[D_W-1:0];
				if (cs_res.ge) begin
					q_q <= '1;
				end else begin
					rem_q <= REM_W'(vm_q >> D2_SHIFT);
					acc_q <= ACC_W'(vm_q) << (ACC_W - D2_SHIFT);
					q_q   <= '0;
				end
			end
			ST_FIN: if (fin_fire_c) res_q <= res_c;
			default: ;
		endcase
	end

endmodule

[hdl/egti_mul.sv]
module egti_mul (
	input  logic                                clk,
	input  logic signed [egti_pkg::MUL_W-1:0]   a,
	input  logic signed [egti_pkg::MUL_W-1:0]   b,
	output logic signed [2*egti_pkg::MUL_W-1:0] prod
);
	import egti_pkg::*;

	logic signed [2*MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

[hdl/egti_cmpsub.sv]
module egti_cmpsub (
	input  logic [egti_pkg::CS_W-1:0] a,
	input  logic [egti_pkg::CS_W-1:0] b,
	output egti_pkg::cs_res_t         res
);
	import egti_pkg::*;

	logic [CS_W:0] sub_c;

	always_comb begin
		sub_c    = {1'b0, a} - {1'b0, b};
		res.ge   = ~sub_c[CS_W];
		res.diff = sub_c[CS_W-1:0];
	end

endmodule
